### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, idle during reset
`define PLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also runs while reset is held
`define PLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/plc_pkg.sv
`default_nettype none
package plc_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int NCMP_W    = 8;

  // divider only sees power_mw * 1000, below 2^26
  localparam int DVD_W  = 26;
  localparam int DSR_W  = 16;
  localparam int DCNT_W = 5;

  localparam logic [15:0] VOLT_RST  = 16'd28000;
  localparam logic [4:0]  COUNT_RST = 5'd16;
  localparam logic [9:0]  MILLI     = 10'd1000;
  // floor(x/1000) == (x * RECIP) >> RECIP_SH for x below 2^26
  localparam logic [26:0] RECIP     = 27'd68719477;
  localparam int          RECIP_SH  = 36;
  localparam logic [31:0] NP_SAT    = 32'd65536000;

  // bus power split: 2^18 = 262 * 1000 + 144
  localparam int          BPROD_W   = 36;
  localparam int          BP_LO_W   = 18;
  localparam logic [8:0]  BP_HI_Q   = 9'd262;
  localparam logic [7:0]  BP_HI_R   = 8'd144;

  localparam logic CFG_VOLT  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_ON   = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_STEP = 2'd2,
    CMD_RSV  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RES_CMD  = 2'd0,
    RES_NONE = 2'd1,
    RES_NODE = 2'd2
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV, S_SUM, S_RESULT, S_SCAN, S_NONE, S_MUL, S_EMIT,
    S_BFOLD, S_BRECIP, S_BINIT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  node_index;
    logic [15:0] power_mw;
    logic [19:0] bus_current_ma;
  } plc_in_t;

  typedef struct packed {
    logic        node_valid;
    logic [3:0]  node_number;
    logic [15:0] node_current_ma;
    logic [15:0] node_power_mw;
    logic [19:0] downstream_current_ma;
    logic [19:0] total_demand_current_ma;
    logic [19:0] total_demand_power_mw;
    logic [26:0] bus_power_mw;
    logic        status;
    logic        last;
  } plc_out_t;

  typedef struct packed {
    logic      latch;
    logic      div_start;
    logic      tbl_wr;
    logic      sum_clr;
    logic      sum_step;
    logic      bp_mul;
    logic      bp_fold;
    logic      bp_recip;
    logic      step_init;
    logic      idx_inc;
    logic      node_load;
    logic      node_mul;
    logic      out_load;
    res_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic bad;
    logic div_done;
    logic node_hit;
    logic any_on;
    logic more_after;
    logic sum_end;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/plc_div.sv
`default_nettype none
module plc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [plc_pkg::DVD_W-1:0] dividend,
  input  wire logic [plc_pkg::DSR_W-1:0] divisor,
  output logic      [plc_pkg::DVD_W-1:0] quot,
  output logic                           done
);
  import plc_pkg::*;
  `include "assert_macros.svh"

  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [DSR_W:0]    rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DSR_W:0]    sh;

  // restoring division, one quotient bit a cycle
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dsr_nxt = dsr_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = done_r;
    sh = {rem_r[DSR_W-1:0], q_r[DVD_W-1]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dsr_nxt = divisor;
      cnt_nxt = '0; busy_nxt = 1'b1; done_nxt = 1'b0;
    end else if (busy_r) begin
      if (sh >= {1'b0, dsr_r}) begin
        rem_nxt = sh - {1'b0, dsr_r};
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dsr_r <= dsr_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

  `PLC_ASSERT(a_start_clears_done, start |=> !done_r, "done after start")
  `PLC_ASSERT(a_not_both, !(busy_r && done_r), "busy and done together")
endmodule
`default_nettype wire

### hw/rtl/plc_dp.sv
`default_nettype none
module plc_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plc_pkg::dp_cmd_t  cmd,
  output plc_pkg::dp_stat_t      stat,
  input  wire plc_pkg::plc_in_t  in_data,
  output plc_pkg::plc_out_t      out_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_wdata
);
  import plc_pkg::*;
  `include "assert_macros.svh"

  logic [15:0] volt_r;
  logic [4:0]  ncount_r;
  plc_in_t     in_r;

  logic        on_r  [MAX_NODES];
  logic [15:0] pw_r  [MAX_NODES];
  logic [15:0] dc_r  [MAX_NODES];
  logic [19:0] tot_cur_r, tot_pw_r;

  logic [IDX_W-1:0]   i_r;
  logic [15:0]        dcv_r;
  logic [BPROD_W-1:0] bprod_r;
  logic [25:0]        bt_r;
  logic [26:0]        bhi_r;
  logic [26:0]        bpow_r;
  logic [19:0]        remain_r;
  logic [15:0]        give_r;
  logic [31:0]        prod_r;
  logic               sat_r;
  logic [52:0]        mq_r;
  plc_out_t           out_r, out_nxt;
  logic               out_valid_r;

  logic [NCMP_W-1:0] n_eff, idx_in;
  logic [IDX_W-1:0]  tidx;
  logic              any_on, more_after;
  logic [DVD_W-1:0]  dvd, quot;
  logic [DSR_W-1:0]  dsr;
  logic              div_done;
  logic [15:0]       dc_sat, give, np;
  logic [20:0]       sum_c, sum_p;
  logic [19:0]       remain_min;
  logic [25:0]       mq_in;

  assign n_eff  = (NCMP_W'(ncount_r) > NCMP_W'(MAX_NODES)) ? NCMP_W'(MAX_NODES)
                                                            : NCMP_W'(ncount_r);
  assign idx_in = NCMP_W'(in_r.node_index);
  assign tidx   = IDX_W'(in_r.node_index);

  always_comb begin
    any_on = 1'b0; more_after = 1'b0;
    for (int j = 0; j < MAX_NODES; j++) begin
      if (on_r[j] && NCMP_W'(j) < n_eff) begin
        any_on = 1'b1;
        if (NCMP_W'(j) > NCMP_W'(i_r)) more_after = 1'b1;
      end
    end
  end

  // divider computes the demand current on turn-on
  assign dvd = DVD_W'(in_r.power_mw) * DVD_W'(MILLI);
  assign dsr = volt_r;

  plc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .quot     (quot),
    .done     (div_done)
  );

  assign dc_sat     = (quot[DVD_W-1:16] != '0) ? 16'hFFFF : quot[15:0];
  assign give       = (20'(dc_r[i_r]) <= remain_r) ? dc_r[i_r] : remain_r[15:0];
  assign np         = sat_r ? 16'hFFFF : mq_r[RECIP_SH+15:RECIP_SH];
  assign sum_c      = {1'b0, tot_cur_r} + 21'(dc_r[i_r]);
  assign sum_p      = {1'b0, tot_pw_r} + 21'(pw_r[i_r]);
  assign remain_min = (in_r.bus_current_ma < tot_cur_r) ? in_r.bus_current_ma : tot_cur_r;
  // shared reciprocal multiplier: folded bus power, or node power
  assign mq_in      = cmd.bp_recip ? bt_r : prod_r[25:0];

  always_comb begin
    out_nxt = '0;
    out_nxt.total_demand_current_ma = tot_cur_r;
    out_nxt.total_demand_power_mw   = tot_pw_r;
    out_nxt.last = 1'b1;
    unique case (cmd.out_kind)
      RES_CMD: begin
        out_nxt.node_number = in_r.node_index;
        if (stat.bad) out_nxt.status = 1'b1;
        else begin
          out_nxt.node_valid = 1'b1;
          if (cmd_t'(in_r.cmd) == CMD_ON) begin
            out_nxt.node_current_ma = dcv_r;
            out_nxt.node_power_mw   = in_r.power_mw;
          end
        end
      end
      RES_NONE: out_nxt.bus_power_mw = bpow_r;
      RES_NODE: begin
        out_nxt.node_valid            = 1'b1;
        out_nxt.node_number           = 4'(i_r);
        out_nxt.node_current_ma       = give_r;
        out_nxt.node_power_mw         = np;
        out_nxt.downstream_current_ma = remain_r;
        out_nxt.bus_power_mw          = bpow_r;
        out_nxt.last                  = !more_after;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r <= VOLT_RST; ncount_r <= COUNT_RST;
      tot_cur_r <= '0; tot_pw_r <= '0; out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_NODES; j++) begin
        on_r[j] <= 1'b0; pw_r[j] <= '0; dc_r[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOLT:  volt_r   <= cfg_wdata;
          CFG_COUNT: ncount_r <= cfg_wdata[4:0];
          default:   ;
        endcase
      end
      if (cmd.tbl_wr) begin
        if (cmd_t'(in_r.cmd) == CMD_ON) begin
          on_r[tidx] <= 1'b1; pw_r[tidx] <= in_r.power_mw; dc_r[tidx] <= dc_sat;
        end else begin
          on_r[tidx] <= 1'b0; pw_r[tidx] <= '0; dc_r[tidx] <= '0;
        end
      end
      if (cmd.sum_clr) begin
        tot_cur_r <= '0; tot_pw_r <= '0;
      end else if (cmd.sum_step && on_r[i_r] && NCMP_W'(i_r) < n_eff) begin
        tot_cur_r <= sum_c[20] ? 20'hFFFFF : sum_c[19:0];
        tot_pw_r  <= sum_p[20] ? 20'hFFFFF : sum_p[19:0];
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (cmd.latch) in_r <= in_data;
    if (cmd.tbl_wr) dcv_r <= dc_sat;
    if (cmd.sum_clr || cmd.step_init) i_r <= '0;
    else if (cmd.sum_step || cmd.idx_inc) i_r <= i_r + 1'b1;
    // bus power: floor(x/1000) = hi * 262 + floor((hi * 144 + lo) / 1000)
    if (cmd.bp_mul) bprod_r <= BPROD_W'(in_r.bus_current_ma) * BPROD_W'(volt_r);
    if (cmd.bp_fold) begin
      bt_r  <= 26'(bprod_r[BPROD_W-1:BP_LO_W]) * 26'(BP_HI_R) + 26'(bprod_r[BP_LO_W-1:0]);
      bhi_r <= 27'(bprod_r[BPROD_W-1:BP_LO_W]) * 27'(BP_HI_Q);
    end
    if (cmd.step_init) begin
      bpow_r <= bhi_r + 27'(mq_r[RECIP_SH+15:RECIP_SH]); remain_r <= remain_min;
    end
    if (cmd.node_load) begin
      give_r <= give; remain_r <= remain_r - 20'(give); prod_r <= give * volt_r;
    end
    if (cmd.node_mul) sat_r <= prod_r >= NP_SAT;
    if (cmd.node_mul || cmd.bp_recip) mq_r <= mq_in * RECIP;
    if (cmd.out_load) out_r <= out_nxt;
  end

  always_comb begin
    stat.cmd        = cmd_t'(in_r.cmd);
    stat.bad        = idx_in >= n_eff;
    stat.div_done   = div_done;
    stat.node_hit   = on_r[i_r] && NCMP_W'(i_r) < n_eff;
    stat.any_on     = any_on;
    stat.more_after = more_after;
    stat.sum_end    = i_r == IDX_W'(MAX_NODES - 1);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  `PLC_ASSERT(a_remain_falls, cmd.node_load |=> remain_r <= $past(remain_r),
              "remaining current grew")
  `PLC_ASSERT(a_load_free, cmd.out_load |-> (!out_valid_r || out_ready),
              "result overwritten")
endmodule
`default_nettype wire

### hw/rtl/plc_ctrl.sv
`default_nettype none
module plc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plc_pkg::dp_stat_t stat,
  output plc_pkg::dp_cmd_t       cmd
);
  import plc_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_kind = RES_CMD;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1; state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_ON, CMD_OFF: begin
            if (stat.bad) state_nxt = S_RESULT;
            else if (stat.cmd == CMD_ON) begin
              cmd.div_start = 1'b1; state_nxt = S_DIV;
            end else begin
              cmd.tbl_wr = 1'b1; cmd.sum_clr = 1'b1; state_nxt = S_SUM;
            end
          end
          CMD_STEP: begin
            cmd.bp_mul = 1'b1; state_nxt = S_BFOLD;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.tbl_wr = 1'b1; cmd.sum_clr = 1'b1; state_nxt = S_SUM;
        end
      end
      S_BFOLD: begin
        cmd.bp_fold = 1'b1; state_nxt = S_BRECIP;
      end
      S_BRECIP: begin
        cmd.bp_recip = 1'b1; state_nxt = S_BINIT;
      end
      S_BINIT: begin
        cmd.step_init = 1'b1; state_nxt = S_SCAN;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_end) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stat.any_on) state_nxt = S_NONE;
        else if (stat.node_hit) begin
          cmd.node_load = 1'b1; state_nxt = S_MUL;
        end else cmd.idx_inc = 1'b1;
      end
      S_NONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1; cmd.out_kind = RES_NONE; state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.node_mul = 1'b1; state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1; cmd.out_kind = RES_NODE;
          if (stat.more_after) begin
            cmd.idx_inc = 1'b1; state_nxt = S_SCAN;
          end else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `PLC_ASSERT(a_last_node_idle,
              (state_r == S_EMIT && stat.out_free && !stat.more_after) |=> state_r == S_IDLE,
              "walk did not end after last node")
  `PLC_ASSERT(a_mul_then_emit, state_r == S_MUL |=> state_r == S_EMIT,
              "multiply stage skipped")
endmodule
`default_nettype wire

### hw/rtl/priority_load_current_allocator_core.sv
`default_nettype none
// priority load current allocator
// input channel in_valid/in_ready carries one command beat: turn a node on,
// turn it off, or run a bus step with a supplied current
// result channel out_valid/out_ready carries result beats; out_data.last
// marks the final beat of a command, reserved commands give no beat
// cfg_we/cfg_index/cfg_wdata write bus voltage (index 0) or node count
// (index 1); the user must write them only while the block is idle, which
// the block itself does not enforce
// turn-on: decode, the 26-step divider computing demand current, the totals
// walk, then loading the result; turn-off: the totals walk alone; index out
// of range: decode, then loading the result; step: bus power (multiply, fold,
// reciprocal, add), then a skip of each off node and select, multiply, emit
// for each on node up to the last on node; with no node on, a single beat
// a new command is taken the cycle after the previous one has handed its
// last beat to the output register, even if that beat still waits for out_ready
// a stalled receiver holds the walk in its emit state; nothing is dropped
// reset (rst_n low, synchronous) clears the node table and totals and
// loads voltage 28000 mV and node count 16
module priority_load_current_allocator_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire plc_pkg::plc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output plc_pkg::plc_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_wdata
);
  import plc_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  plc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dstat),
    .cmd      (dcmd)
  );

  // node table, totals, divider, allocation walk and result register
  plc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dcmd),
    .stat      (dstat),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );
endmodule
`default_nettype wire

### tb/priority_load_current_allocator_core_tb.sv
module priority_load_current_allocator_core_tb;
  import plc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles the block may still be busy after the last beat (reserved commands
  // give no beat)
  localparam int DRAIN_CYCLES = 150;
  // slowest correct run with all stalls, taken several times over
  localparam int CYCLE_LIMIT  = 1500000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  plc_in_t     in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  plc_out_t    out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  priority_load_current_allocator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the load table and bus registers
  logic [15:0] bus_mv;
  logic [4:0]  node_cnt;
  logic        load_on  [MAX_NODES];
  logic [15:0] load_pow [MAX_NODES];
  logic [15:0] load_cur [MAX_NODES];
  logic [19:0] sum_cur;
  logic [19:0] sum_pow;

  plc_out_t alloc_beats[$];   // expected result beats, oldest first

  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  int unsigned idle_pct  = 0;  // sender gap chance in percent
  int unsigned stall_pct = 0;  // receiver stall chance in percent
  int unsigned hold_left = 0;  // long receiver hold-off, in cycles

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("priority_load_current_allocator_core_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int unsigned live_nodes();
    return (node_cnt < MAX_NODES) ? node_cnt : MAX_NODES;
  endfunction

  task automatic retotal();
    int unsigned ic, pc;
    ic = 0;
    pc = 0;
    for (int i = 0; i < live_nodes(); i++) begin
      if (load_on[i]) begin
        ic += load_cur[i];
        pc += load_pow[i];
      end
    end
    sum_cur = (ic > 20'hFFFFF) ? 20'hFFFFF : ic[19:0];
    sum_pow = (pc > 20'hFFFFF) ? 20'hFFFFF : pc[19:0];
  endtask

  function automatic plc_out_t alloc_beat(logic vld, logic [3:0] num, logic [15:0] cur,
                                          logic [15:0] pow, logic [19:0] down,
                                          logic [26:0] bpow, logic st);
    plc_out_t b;
    b.node_valid              = vld;
    b.node_number             = num;
    b.node_current_ma         = cur;
    b.node_power_mw           = pow;
    b.downstream_current_ma   = down;
    b.total_demand_current_ma = sum_cur;
    b.total_demand_power_mw   = sum_pow;
    b.bus_power_mw            = bpow;
    b.status                  = st;
    b.last                    = 1'b0;
    return b;
  endfunction

  // work out the beats one accepted command causes and update the table
  task automatic predict_alloc(plc_in_t item);
    longint unsigned v, dc, bpow, remain, give, np;
    int unsigned n;
    int k;
    v = bus_mv;
    n = live_nodes();
    case (cmd_t'(item.cmd))
      CMD_ON, CMD_OFF: begin
        if (item.node_index >= n) begin
          // index not below the node count: nothing changes, flagged
          alloc_beats.push_back(alloc_beat(1'b0, item.node_index, '0, '0, '0, '0, 1'b1));
        end else if (cmd_t'(item.cmd) == CMD_ON) begin
          dc = (v == 0) ? 64'hFFFF : (longint'(item.power_mw) * 1000) / v;
          if (dc > 64'hFFFF) dc = 64'hFFFF;
          load_on[item.node_index]  = 1'b1;
          load_pow[item.node_index] = item.power_mw;
          load_cur[item.node_index] = dc[15:0];
          retotal();
          alloc_beats.push_back(alloc_beat(1'b1, item.node_index, dc[15:0], item.power_mw,
                                           '0, '0, 1'b0));
        end else begin
          load_on[item.node_index]  = 1'b0;
          load_pow[item.node_index] = '0;
          load_cur[item.node_index] = '0;
          retotal();
          alloc_beats.push_back(alloc_beat(1'b1, item.node_index, '0, '0, '0, '0, 1'b0));
        end
        alloc_beats[alloc_beats.size()-1].last = 1'b1;
      end
      CMD_STEP: begin
        bpow   = (longint'(item.bus_current_ma) * v) / 1000;
        remain = (item.bus_current_ma < sum_cur) ? item.bus_current_ma : sum_cur;
        k      = 0;
        // priority walk in index order over the stale totals
        for (int i = 0; i < n; i++) begin
          if (load_on[i]) begin
            give   = (load_cur[i] <= remain) ? load_cur[i] : remain;
            remain = remain - give;
            np     = (give * v) / 1000;
            if (np > 64'hFFFF) np = 64'hFFFF;
            alloc_beats.push_back(alloc_beat(1'b1, i[3:0], give[15:0], np[15:0],
                                             remain[19:0], bpow[26:0], 1'b0));
            k++;
          end
        end
        if (k == 0) alloc_beats.push_back(alloc_beat(1'b0, '0, '0, '0, '0, bpow[26:0], 1'b0));
        alloc_beats[alloc_beats.size()-1].last = 1'b1;
      end
      default: ;  // reserved: no beat
    endcase
  endtask

  // result checker
  always @(negedge clk) begin
    plc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (alloc_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = alloc_beats.pop_front();
        if (out_data.node_valid !== want.node_valid ||
            out_data.node_number !== want.node_number ||
            out_data.node_current_ma !== want.node_current_ma ||
            out_data.node_power_mw !== want.node_power_mw ||
            out_data.downstream_current_ma !== want.downstream_current_ma ||
            out_data.total_demand_current_ma !== want.total_demand_current_ma ||
            out_data.total_demand_power_mw !== want.total_demand_power_mw ||
            out_data.bus_power_mw !== want.bus_power_mw ||
            out_data.status !== want.status ||
            out_data.last !== want.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  // offer one command beat, hold it until taken
  task automatic send_cmd(plc_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_alloc(item);
  endtask

  function automatic plc_in_t make_cmd(cmd_t c, int unsigned idx, int unsigned pw,
                                       int unsigned cur);
    plc_in_t t;
    t.cmd            = c;
    t.node_index     = idx[3:0];
    t.power_mw       = pw[15:0];
    t.bus_current_ma = cur[19:0];
    return t;
  endfunction

  // wait for every expected beat plus the block's tail latency
  task automatic drain();
    in_valid <= 1'b0;
    while (alloc_beats.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_VOLT) bus_mv = val;
    else node_cnt = val[4:0];
  endtask

  function automatic int unsigned rand_power();
    return ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(5000);
  endfunction

  function automatic int unsigned rand_current();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return $urandom_range(20'hFFFFF);
    if (r < 7) return (sum_cur > 200) ? sum_cur - 200 + $urandom_range(400) : $urandom_range(400);
    return $urandom_range(3000);
  endfunction

  task automatic test_directed();
    // step with nothing on, then field extremes
    send_cmd(make_cmd(CMD_STEP, 0, 0, 12345));
    send_cmd(make_cmd(CMD_ON, 0, 0, 0));
    send_cmd(make_cmd(CMD_ON, 15, 65535, 0));
    send_cmd(make_cmd(CMD_ON, 3, 1234, 20'hFFFFF));
    send_cmd(make_cmd(CMD_ON, 8, 30000, 0));
    send_cmd(make_cmd(CMD_STEP, 0, 0, 0));
    send_cmd(make_cmd(CMD_STEP, 0, 0, 20'hFFFFF));
    send_cmd(make_cmd(CMD_STEP, 0, 65535, 1500));   // partial allocation
    send_cmd(make_cmd(CMD_OFF, 7, 0, 0));           // off node turned off again
    send_cmd(make_cmd(CMD_OFF, 15, 65535, 0));
    send_cmd(make_cmd(CMD_RSV, 5, 999, 999));       // reserved, silent
    send_cmd(make_cmd(CMD_STEP, 0, 0, 800));
    // index out of range against a short table
    write_reg(CFG_COUNT, 16'd4);
    send_cmd(make_cmd(CMD_ON, 4, 100, 0));
    send_cmd(make_cmd(CMD_OFF, 15, 0, 0));
    send_cmd(make_cmd(CMD_STEP, 0, 0, 5000));
    // very low and zero voltage saturate the demand current
    write_reg(CFG_VOLT, 16'd1);
    send_cmd(make_cmd(CMD_ON, 1, 65535, 0));
    write_reg(CFG_VOLT, 16'd0);
    send_cmd(make_cmd(CMD_ON, 2, 7, 0));
    send_cmd(make_cmd(CMD_STEP, 0, 0, 20'hFFFFF));
    write_reg(CFG_COUNT, 16'd16);
    write_reg(CFG_VOLT, 16'd28000);
  endtask

  // mostly load-up sequences closed by a step, plus raw noise
  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    int unsigned sent, ons, lim;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 70) begin
        ons = $urandom_range(5, 1);
        lim = (live_nodes() > 0) ? live_nodes() - 1 : 15;
        repeat (ons) begin
          if ($urandom_range(4) == 0)
            send_cmd(make_cmd(CMD_OFF, $urandom_range(lim), rand_power(), 0));
          else
            send_cmd(make_cmd(CMD_ON, $urandom_range(lim), rand_power(),
                              $urandom_range(20'hFFFFF)));
        end
        send_cmd(make_cmd(CMD_STEP, $urandom_range(15), $urandom_range(65535),
                          rand_current()));
        sent += ons + 1;
      end else begin
        send_cmd(make_cmd(cmd_t'($urandom_range(3)), $urandom_range(15), rand_power(),
                          $urandom_range(20'hFFFFF)));
        sent++;
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // receiver holds off while the sender keeps offering, block must stall input
  task automatic test_backpressure();
    hold_left = 600;
    repeat (20) send_cmd(make_cmd(CMD_STEP, 0, 0, rand_current()));
    repeat (6) send_cmd(make_cmd(CMD_ON, $urandom_range(15), rand_power(), 0));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    bus_mv    = VOLT_RST;
    node_cnt  = COUNT_RST;
    for (int i = 0; i < MAX_NODES; i++) begin
      load_on[i]  = 1'b0;
      load_pow[i] = '0;
      load_cur[i] = '0;
    end
    sum_cur = '0;
    sum_pow = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(40, 0, 0);
    write_reg(CFG_VOLT, 16'd65535);
    test_random(35, 88, 0);
    write_reg(CFG_VOLT, 16'd1000);
    write_reg(CFG_COUNT, 16'd5);
    test_random(35, 0, 88);
    write_reg(CFG_VOLT, 16'd0);
    write_reg(CFG_COUNT, 16'd31);
    test_random(30, 30, 30);
    write_reg(CFG_VOLT, 16'd12345);
    write_reg(CFG_COUNT, 16'd0);
    test_random(10, 30, 30);
    write_reg(CFG_COUNT, 16'd1);
    test_random(10, 0, 0);
    write_reg(CFG_VOLT, 16'd28000);
    write_reg(CFG_COUNT, 16'd16);
    test_backpressure();
    test_random(16, 30, 30);

    drain();
    if (errors == 0) begin
      $display("priority_load_current_allocator_core_tb: done, clean");
    end else begin
      $display("priority_load_current_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
